/* sv/des_block_encrypt_top_assert.svh */
// assertion macros for the des block encryptor top level
// used by des_block_encrypt_top.sv, no other dependencies
`ifndef DES_BLOCK_ENCRYPT_TOP_ASSERT_SVH
`define DES_BLOCK_ENCRYPT_TOP_ASSERT_SVH

// property a implies property b at the next edge
`define DBE_ASSERT_NEXT(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("des assertion failed");

// property a implies property b at the same edge
`define DBE_ASSERT_NOW(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("des assertion failed");

`endif

/* sv/des_pkg.sv */
`timescale 1ns / 1ps
// des package: tables, round count and round helper functions
// no dependencies
package des_pkg;

   localparam int unsigned NumRounds = 16;
   localparam logic [31:0] CsrAddrKeyLo = 32'd0;

   typedef logic [63:0] block_type;
   typedef logic [55:0] cd_type;

   typedef byte unsigned perm64_type [64];
   typedef byte unsigned perm56_type [56];
   typedef byte unsigned perm48_type [48];
   typedef byte unsigned perm32_type [32];

   localparam perm64_type IP_TAB = '{
      58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,62,54,46,38,30,22,14,6,
      64,56,48,40,32,24,16,8,57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
      61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
   localparam perm64_type FP_TAB = '{
      40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,38,6,46,14,54,22,62,30,
      37,5,45,13,53,21,61,29,36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
      34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
   localparam perm48_type EXP_TAB = '{
      32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
      16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
   localparam perm32_type P_TAB = '{
      16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
      2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
   localparam perm56_type PC1_TAB = '{
      57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
      60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
      29,21,13,5,28,20,12,4};
   localparam perm48_type PC2_TAB = '{
      14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
      41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
   localparam logic [NumRounds-1:0] ROT2_MASK = 16'b0111_1110_1111_1100;

   typedef logic [3:0] sbox_row_type [64];
   typedef sbox_row_type sbox_all_type [8];
   localparam sbox_all_type SBOX_TAB = '{
      '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
      '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
      '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
      '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
      '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
      '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
      '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
      '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

   // initial permutation
   function automatic logic [63:0] ip_perm(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 64; i++) r[63-i] = v[64-IP_TAB[i]];
      return r;
   endfunction

   // inverse initial permutation
   function automatic logic [63:0] fp_perm(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 64; i++) r[63-i] = v[64-FP_TAB[i]];
      return r;
   endfunction

   // key permuted choice one
   function automatic cd_type pc1_perm(input logic [63:0] v);
      cd_type r;
      for (int i = 0; i < 56; i++) r[55-i] = v[64-PC1_TAB[i]];
      return r;
   endfunction

   // per-round rotation of both 28-bit halves
   function automatic cd_type rot_cd(input cd_type v, input logic two);
      cd_type r;
      if (two) begin
         r = {v[53:28], v[55:54], v[25:0], v[27:26]};
      end else begin
         r = {v[54:28], v[55], v[26:0], v[27]};
      end
      return r;
   endfunction

   // key permuted choice two
   function automatic logic [47:0] pc2_perm(input cd_type v);
      logic [47:0] r;
      for (int i = 0; i < 48; i++) r[47-i] = v[56-PC2_TAB[i]];
      return r;
   endfunction

   // feistel function: expansion, key mix, s-boxes, p permutation
   function automatic logic [31:0] feistel(input logic [31:0] rgt, input logic [47:0] rk);
      logic [47:0] x;
      logic [31:0] s;
      logic [31:0] r;
      logic [5:0] six;
      for (int i = 0; i < 48; i++) x[47-i] = rgt[32-EXP_TAB[i]];
      x = x ^ rk;
      for (int j = 0; j < 8; j++) begin
         six = x[47-6*j -: 6];
         s[31-4*j -: 4] = SBOX_TAB[j][{six[5], six[0], six[4:1]}];
      end
      for (int i = 0; i < 32; i++) r[31-i] = s[32-P_TAB[i]];
      return r;
   endfunction

endpackage

/* sv/des_block_encrypt_top.sv */
`timescale 1ns / 1ps
// des block encryptor top level: key register, input permutation, round pipeline
// depends on des_pkg, des_round and des_block_encrypt_top_assert.svh
//
//   channel  direction  ports
//   req      in         req_valid, req_ready, req_plaintext
//   rsp      out        rsp_valid, rsp_ready, rsp_ciphertext
//   csr      in         apb write of key_ff at address 0; reads return key_ff
//
// one block per cycle unless the output stalls; stages: input register, sixteen round stages,
// output register. every stage holds while the stage after it is full and stalled.
// reset clears valid bits and the key; the key is captured with each block.
module des_block_encrypt_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_plaintext,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_ciphertext,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);
   localparam int unsigned N = des_pkg::NumRounds;

   logic [63:0]     key_ff;
   logic            in_valid_ff;
   logic [63:0]     in_halves_ff;
   des_pkg::cd_type in_cd_ff;
   logic            in_stage_ready;
   logic            out_valid_ff;
   logic [63:0]     out_ff;
   logic            last_ready;

   logic            v [N+1];
   logic            rdy [N+1];
   logic [63:0]     h [N+1];
   des_pkg::cd_type c [N+1];

   // key register
   assign pready = 1'b1;
   assign prdata = key_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (psel && penable && pwrite && paddr == des_pkg::CsrAddrKeyLo[2:0]) begin
         key_ff <= pwdata;
      end
   end

   // input stage: initial permutation and pc1
   assign req_ready = !in_valid_ff || in_stage_ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_halves_ff <= des_pkg::ip_perm(req_plaintext);
         in_cd_ff <= des_pkg::pc1_perm(key_ff);
      end
   end

   assign v[0] = in_valid_ff;
   assign h[0] = in_halves_ff;
   assign c[0] = in_cd_ff;
   assign in_stage_ready = rdy[0];

   // sixteen round stages
   for (genvar r = 0; r < N; r++) begin : g_round
      des_round u_round (
         .clock      (clock),
         .reset      (reset),
         .rot_two    (des_pkg::ROT2_MASK[r]),
         .in_valid   (v[r]),
         .in_ready   (rdy[r]),
         .in_halves  (h[r]),
         .in_cd      (c[r]),
         .out_valid  (v[r+1]),
         .out_ready  (rdy[r+1]),
         .out_halves (h[r+1]),
         .out_cd     (c[r+1])
      );
   end

   // output stage: swap and inverse permutation
   assign last_ready = !out_valid_ff || rsp_ready;
   assign rdy[N] = last_ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (last_ready) begin
         out_valid_ff <= v[N];
      end
   end
   always_ff @(posedge clock) begin
      if (last_ready && v[N]) begin
         out_ff <= des_pkg::fp_perm({h[N][31:0], h[N][63:32]});
      end
   end
   assign rsp_valid = out_valid_ff;
   assign rsp_ciphertext = out_ff;

   `include "des_block_encrypt_top_assert.svh"

   `DBE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_ciphertext))
   `DBE_ASSERT_NOW(a_ready_when_empty, !in_valid_ff, req_ready)
   `DBE_ASSERT_NEXT(a_last_lands, v[N] && last_ready, out_valid_ff)
endmodule

/* sv/des_round.sv */
`timescale 1ns / 1ps
// one feistel round stage with its key schedule step and stall handling
// depends on des_pkg
module des_round (
   input  logic             clock,
   input  logic             reset,
   input  logic             rot_two,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [63:0]      in_halves,
   input  des_pkg::cd_type  in_cd,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [63:0]      out_halves,
   output des_pkg::cd_type  out_cd
);
   logic            valid_ff;
   logic [63:0]     halves_ff;
   logic [63:0]     halves_in;
   des_pkg::cd_type cd_ff;
   des_pkg::cd_type cd_in;

   assign in_ready = !valid_ff || out_ready;

   // round datapath
   always_comb begin
      cd_in = des_pkg::rot_cd(in_cd, rot_two);
      halves_in = {in_halves[31:0],
                   in_halves[63:32] ^ des_pkg::feistel(in_halves[31:0],
                                                       des_pkg::pc2_perm(cd_in))};
   end

   // stage valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         halves_ff <= halves_in;
         cd_ff <= cd_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_halves = halves_ff;
   assign out_cd = cd_ff;
endmodule

/* dv/tb_des_block_encrypt_top.sv */
`timescale 1ns / 1ps
// self-checking testbench for the des block encryptor: drives plaintext and key writes,
// predicts each ciphertext with its own des model, checks results in order
// depends on des_pkg (tables only) and des_block_encrypt_top
module tb_des_block_encrypt_top;

   localparam int unsigned PipeLatency = 18;
   localparam int unsigned CycleLimit = 400000;
   localparam logic [2:0] KeyAddr = 3'd0;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_plaintext;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_ciphertext;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [63:0] pwdata;
   logic [63:0] prdata;
   logic        pready;

   logic [63:0] key_shadow;
   logic [63:0] cipher_queue[$];
   int unsigned mismatch_count;
   int unsigned result_count;
   int unsigned sent_count;
   int unsigned cycle_count;
   int unsigned hold_cycles;
   bit          sink_random;

   des_block_encrypt_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_plaintext(req_plaintext),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_ciphertext(rsp_ciphertext),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // generic table permutation, table entries count from the msb
   function automatic logic [63:0] tab_permute(input logic [63:0] v, input int inw,
                                               input byte unsigned tab[], input int outw);
      logic [63:0] r;
      r = '0;
      for (int i = 0; i < outw; i++) r = (r << 1) | 64'(v[inw - tab[i]]);
      return r;
   endfunction

   function automatic logic [27:0] rotl28(input logic [27:0] h, input int s);
      return (h << s) | (h >> (28 - s));
   endfunction

   // single des encryption of one block
   function automatic logic [63:0] des_encrypt(input logic [63:0] key, input logic [63:0] pt);
      byte unsigned t_ip[], t_fp[], t_pc1[], t_pc2[], t_exp[], t_p[];
      logic [55:0] cd;
      logic [27:0] c, d;
      logic [63:0] blk;
      logic [31:0] lh, rh, nr, f, s;
      logic [47:0] rk, x;
      logic [5:0]  six;
      t_ip = new[64]; t_fp = new[64]; t_pc1 = new[56]; t_pc2 = new[48];
      t_exp = new[48]; t_p = new[32];
      foreach (des_pkg::IP_TAB[i]) begin
         t_ip[i] = des_pkg::IP_TAB[i];
         t_fp[i] = des_pkg::FP_TAB[i];
      end
      foreach (des_pkg::PC1_TAB[i]) t_pc1[i] = des_pkg::PC1_TAB[i];
      foreach (des_pkg::PC2_TAB[i]) begin
         t_pc2[i] = des_pkg::PC2_TAB[i];
         t_exp[i] = des_pkg::EXP_TAB[i];
      end
      foreach (des_pkg::P_TAB[i]) t_p[i] = des_pkg::P_TAB[i];
      cd = 56'(tab_permute(key, 64, t_pc1, 56));
      c = cd[55:28];
      d = cd[27:0];
      blk = tab_permute(pt, 64, t_ip, 64);
      lh = blk[63:32];
      rh = blk[31:0];
      for (int r = 0; r < 16; r++) begin
         // rounds 1, 2, 9 and 16 rotate by one
         if (r == 0 || r == 1 || r == 8 || r == 15) begin
            c = rotl28(c, 1); d = rotl28(d, 1);
         end else begin
            c = rotl28(c, 2); d = rotl28(d, 2);
         end
         rk = 48'(tab_permute({8'h0, c, d}, 56, t_pc2, 48));
         x = 48'(tab_permute({32'h0, rh}, 32, t_exp, 48)) ^ rk;
         for (int j = 0; j < 8; j++) begin
            six = x[47-6*j -: 6];
            s[31-4*j -: 4] = des_pkg::SBOX_TAB[j][{six[5], six[0], six[4:1]}];
         end
         f = 32'(tab_permute({32'h0, s}, 32, t_p, 32));
         nr = lh ^ f;
         lh = rh;
         rh = nr;
      end
      return tab_permute({rh, lh}, 64, t_fp, 64);
   endfunction

   // cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb: failure");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      logic [63:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         result_count <= result_count + 1;
         if (cipher_queue.size() == 0) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10) $display("unexpected ciphertext %h", rsp_ciphertext);
         end else begin
            want = cipher_queue.pop_front();
            if (rsp_ciphertext !== want) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("ciphertext mismatch: expected %h actual %h", want, rsp_ciphertext);
            end
         end
      end
   end

   // receiver stalls: random gaps, or a counted long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else if (!sink_random) begin
         rsp_ready <= 1'b1;
      end else begin
         case ($urandom_range(0, 19))
            0: hold_cycles <= $urandom_range(10, 40);
            1, 2, 3, 4: rsp_ready <= 1'b0;
            default: rsp_ready <= 1'b1;
         endcase
      end
   end

   // send one plaintext transfer, prediction uses the key current at acceptance
   // valid stays high afterwards until a gap or a drain drops it
   task automatic send_block(input logic [63:0] pt);
      req_valid <= 1'b1;
      req_plaintext <= pt;
      do @(posedge clock); while (!req_ready);
      cipher_queue.push_back(des_encrypt(key_shadow, pt));
      sent_count++;
   endtask

   task automatic idle_gap();
      int unsigned n;
      case ($urandom_range(0, 19))
         0: n = $urandom_range(8, 30);
         1, 2, 3, 4, 5: n = $urandom_range(1, 3);
         default: n = 0;
      endcase
      if (n != 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (cipher_queue.size() != 0) @(posedge clock);
      repeat (PipeLatency + 4) @(posedge clock);
   endtask

   // apb write of the key, only while the pipeline is empty
   task automatic write_key(input logic [63:0] key);
      logic [63:0] rd;
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= KeyAddr; pwdata <= key;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      key_shadow = key;
      // read back
      @(posedge clock);
      psel <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rd = prdata;
      psel <= 1'b0; penable <= 1'b0;
      if (rd !== key) begin
         mismatch_count++;
         if (mismatch_count <= 10) $display("key readback: expected %h actual %h", key, rd);
      end
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // extremes, walking bits, the standard known-answer block and weak keys
   task automatic test_directed();
      send_block(64'h0);
      send_block('1);
      drain_pipe();
      write_key(64'h1334_5779_9BBC_DFF1);
      send_block(64'h0123_4567_89AB_CDEF);
      send_block(64'h0);
      send_block('1);
      for (int i = 0; i < 64; i += 9) send_block(64'h1 << i);
      drain_pipe();
      write_key('1);
      send_block(64'h0);
      send_block(64'h8000_0000_0000_0001);
      drain_pipe();
      // weak key and a key that differs only in parity bits
      write_key(64'h0101_0101_0101_0101);
      send_block(64'h5555_AAAA_5555_AAAA);
      send_block('1);
      drain_pipe();
      write_key(64'h0000_0000_0000_0000);
      send_block(64'h5555_AAAA_5555_AAAA);
      drain_pipe();
   endtask

   // random blocks under several random keys with random gaps on both sides
   task automatic test_random(input int unsigned phases, input int unsigned per_phase);
      sink_random = 1'b1;
      for (int p = 0; p < phases; p++) begin
         write_key(rand64());
         for (int i = 0; i < per_phase; i++) begin
            send_block(rand64());
            idle_gap();
         end
         drain_pipe();
      end
   endtask

   // receiver holds off while the sender streams, so the pipeline backs up; then a run with the receiver always ready
   task automatic test_backpressure();
      write_key(rand64());
      hold_cycles = 60;
      for (int i = 0; i < 50; i++) send_block(rand64());
      // sender pauses until every result is back
      drain_pipe();
      sink_random = 1'b0;
      for (int i = 0; i < 40; i++) send_block(rand64());
      drain_pipe();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0; req_plaintext = '0; psel = 1'b0; penable = 1'b0;
      pwrite = 1'b0; paddr = KeyAddr; pwdata = '0;
      key_shadow = '0;
      mismatch_count = 0; result_count = 0; sent_count = 0; cycle_count = 0;
      hold_cycles = 0; sink_random = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(10, 150);
      test_backpressure();
      $display("sent %0d blocks, checked %0d ciphertexts, %0d mismatches",
               sent_count, result_count, mismatch_count);
      if (mismatch_count == 0 && cipher_queue.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
